FILE: hw/rtl/cfrb_pkg.sv
`default_nettype none

package cfrb_pkg;

	// default ring depths
	localparam int RxSlotsDefault = 8;
	localparam int TxSlotsDefault = 8;

	// field widths
	localparam int OpW   = 3;
	localparam int HdrW  = 32;
	localparam int IdW   = 29;
	localparam int LbW   = 8;
	localparam int LenW  = 4;
	localparam int DataW = 64;
	localparam int SlotW = 3;
	localparam int KindW = 4;

	localparam logic [LenW-1:0] MaxLen  = 4'd8;
	localparam logic [7:0]      ExtFlag = 8'h08;

	// operation codes
	localparam logic [OpW-1:0] OP_RX_FRAME    = 3'd0;
	localparam logic [OpW-1:0] OP_TX_EMPTY    = 3'd1;
	localparam logic [OpW-1:0] OP_HOST_READ   = 3'd2;
	localparam logic [OpW-1:0] OP_HOST_FREE   = 3'd3;
	localparam logic [OpW-1:0] OP_HOST_SUBMIT = 3'd4;

	// result kinds
	localparam logic [KindW-1:0] KIND_STORED   = 4'd0;
	localparam logic [KindW-1:0] KIND_DROPPED  = 4'd1;
	localparam logic [KindW-1:0] KIND_TX_LOAD  = 4'd2;
	localparam logic [KindW-1:0] KIND_TX_IDLE  = 4'd3;
	localparam logic [KindW-1:0] KIND_RX_FRAME = 4'd4;
	localparam logic [KindW-1:0] KIND_RX_EMPTY = 4'd5;
	localparam logic [KindW-1:0] KIND_FREED    = 4'd6;
	localparam logic [KindW-1:0] KIND_QUEUED   = 4'd7;
	localparam logic [KindW-1:0] KIND_FULL     = 4'd8;

	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [HdrW-1:0]  raw_header;
		logic [IdW-1:0]   frame_id;
		logic [LbW-1:0]   length_byte;
		logic [DataW-1:0] payload;
		logic [SlotW-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [IdW-1:0]   out_id;
		logic [LenW-1:0]  out_length;
		logic [DataW-1:0] out_payload;
		logic [SlotW-1:0] out_slot;
		logic [HdrW-1:0]  packed_header;
	} rsp_t;

	// one ring slot
	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [LenW-1:0]  len;
		logic [DataW-1:0] data;
	} frame_t;

	localparam int FrameW = $bits(frame_t);

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_known;
		logic out_free;
	} sts_t;

	// low nibble of the length byte, clamped to eight
	function automatic logic [LenW-1:0] clamp_len(input logic [LbW-1:0] lb);
		return (lb[3:0] > MaxLen) ? MaxLen : lb[3:0];
	endfunction

	// zero the data bytes at and above the length
	function automatic logic [DataW-1:0] trim_data(input logic [DataW-1:0] d,
		input logic [LenW-1:0] len);
		logic [DataW-1:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = (LenW'(i) < len) ? d[8*i +: 8] : 8'h00;
		end
		return r;
	endfunction

	// raw header bytes -> 29-bit identifier
	function automatic logic [IdW-1:0] unpack_id(input logic [HdrW-1:0] h);
		return {h[31:24], h[23:21], h[17:16], h[15:8], h[7:0]};
	endfunction

	// identifier -> header bytes, extended flag set
	function automatic logic [HdrW-1:0] pack_id(input logic [IdW-1:0] id);
		logic [7:0] b1;
		b1 = {id[20:18], 5'b00000} | ExtFlag | {6'b000000, id[17:16]};
		return {id[28:21], b1, id[15:8], id[7:0]};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cfrb_stream_if.sv
`default_nettype none

interface cfrb_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cfrb_ram.sv
`default_nettype none

module cfrb_ram #(
	parameter  int Width = 8,
	parameter  int Depth = 8,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// one write port, one registered read port; read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cfrb_ctrl.sv
`default_nettype none

module cfrb_ctrl import cfrb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output logic      in_ready,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// take a beat in idle; for a known op code, hand its result to the output register once that is free
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.op_known) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cfrb_datapath.sv
`default_nettype none

module cfrb_datapath import cfrb_pkg::*; #(
	parameter int RX_SLOTS = RxSlotsDefault,
	parameter int TX_SLOTS = TxSlotsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output rsp_t      rsp,
	output logic      rsp_valid,
	input  wire logic rsp_ready
);

	localparam int RxPw = $clog2(RX_SLOTS);
	localparam int TxPw = $clog2(TX_SLOTS);

	typedef enum logic [1:0] {
		SRC_REG    = 2'd0,
		SRC_RX_MEM = 2'd1,
		SRC_TX_MEM = 2'd2
	} src_t;

	// ring control state
	logic [RxPw-1:0]     rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TxPw-1:0]     tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic [RX_SLOTS-1:0] rx_used_q, rx_used_d;
	logic [TX_SLOTS-1:0] tx_pending_q, tx_pending_d;
	logic                tx_busy_q, tx_busy_d;

	// pending result
	logic [KindW-1:0] res_kind_q, res_kind_d;
	logic [SlotW-1:0] res_slot_q, res_slot_d;
	frame_t           res_frame_q, res_frame_d;
	src_t             res_src_q, res_src_d;

	// memory ports
	logic   rx_we, rx_re, tx_we, tx_re;
	frame_t rx_rdata, tx_rdata;
	logic   rx_store, tx_launch;

	// output register
	rsp_t rsp_q, rsp_d;
	logic out_valid_q;
	frame_t frame_sel;

	// incoming frame fields
	logic [LenW-1:0]  len_in;
	logic [DataW-1:0] data_in;
	frame_t           rx_frame_in, tx_frame_in;

	assign len_in      = clamp_len(req.length_byte);
	assign data_in     = trim_data(req.payload, len_in);
	assign rx_frame_in = '{id: unpack_id(req.raw_header), len: len_in, data: data_in};
	assign tx_frame_in = '{id: req.frame_id, len: len_in, data: data_in};

	assign sts.op_known = (req.op <= OP_HOST_SUBMIT);
	assign sts.out_free = !out_valid_q || rsp_ready;

	// operation decode: flags, pointers, memory access, result selection
	always_comb begin
		rx_head_d    = rx_head_q;
		rx_tail_d    = rx_tail_q;
		tx_head_d    = tx_head_q;
		tx_tail_d    = tx_tail_q;
		rx_used_d    = rx_used_q;
		tx_pending_d = tx_pending_q;
		tx_busy_d    = tx_busy_q;
		rx_we        = 1'b0;
		rx_re        = 1'b0;
		tx_we        = 1'b0;
		tx_re        = 1'b0;
		rx_store     = 1'b0;
		tx_launch    = 1'b0;
		res_kind_d   = KIND_DROPPED;
		res_slot_d   = '0;
		res_frame_d  = '0;
		res_src_d    = SRC_REG;
		if (cmd.accept) begin
			unique case (req.op)
				OP_RX_FRAME: begin
					if (rx_used_q[rx_head_q]) begin
						res_kind_d = KIND_DROPPED;
					end else begin
						rx_store              = 1'b1;
						rx_we                 = 1'b1;
						rx_used_d[rx_head_q]  = 1'b1;
						rx_head_d = (rx_head_q == RxPw'(RX_SLOTS - 1)) ? '0 : rx_head_q + 1'b1;
						res_kind_d  = KIND_STORED;
						res_slot_d  = SlotW'(rx_head_q);
						res_frame_d = rx_frame_in;
					end
				end
				OP_TX_EMPTY: begin
					if (tx_pending_q[tx_tail_q]) begin
						tx_launch               = 1'b1;
						tx_re                   = 1'b1;
						tx_pending_d[tx_tail_q] = 1'b0;
						tx_busy_d               = 1'b1;
						tx_tail_d = (tx_tail_q == TxPw'(TX_SLOTS - 1)) ? '0 : tx_tail_q + 1'b1;
						res_kind_d = KIND_TX_LOAD;
						res_src_d  = SRC_TX_MEM;
					end else begin
						tx_busy_d  = 1'b0;
						res_kind_d = KIND_TX_IDLE;
					end
				end
				OP_HOST_READ: begin
					if (rx_head_q == rx_tail_q) begin
						res_kind_d = KIND_RX_EMPTY;
					end else begin
						rx_re      = 1'b1;
						rx_tail_d = (rx_tail_q == RxPw'(RX_SLOTS - 1)) ? '0 : rx_tail_q + 1'b1;
						res_kind_d = KIND_RX_FRAME;
						res_slot_d = SlotW'(rx_tail_q);
						res_src_d  = SRC_RX_MEM;
					end
				end
				OP_HOST_FREE: begin
					if (int'(req.slot_index) < RX_SLOTS) begin
						rx_used_d[RxPw'(req.slot_index)] = 1'b0;
					end
					res_kind_d = KIND_FREED;
					res_slot_d = req.slot_index;
				end
				OP_HOST_SUBMIT: begin
					if (tx_pending_q[tx_head_q]) begin
						res_kind_d = KIND_FULL;
					end else begin
						tx_we                   = 1'b1;
						tx_pending_d[tx_head_q] = 1'b1;
						tx_head_d = (tx_head_q == TxPw'(TX_SLOTS - 1)) ? '0 : tx_head_q + 1'b1;
						if (!tx_busy_q && tx_pending_d[tx_tail_q]) begin
							tx_launch               = 1'b1;
							tx_pending_d[tx_tail_q] = 1'b0;
							tx_busy_d               = 1'b1;
							tx_tail_d = (tx_tail_q == TxPw'(TX_SLOTS - 1)) ? '0 : tx_tail_q + 1'b1;
							res_kind_d = KIND_TX_LOAD;
							// launching the slot just written: forward it
							if (tx_tail_q == tx_head_q) begin
								res_frame_d = tx_frame_in;
							end else begin
								tx_re     = 1'b1;
								res_src_d = SRC_TX_MEM;
							end
						end else begin
							res_kind_d  = KIND_QUEUED;
							res_frame_d = tx_frame_in;
						end
					end
				end
				default: res_kind_d = KIND_DROPPED;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			rx_used_q    <= '0;
			tx_pending_q <= '0;
			tx_busy_q    <= 1'b0;
		end else begin
			rx_head_q    <= rx_head_d;
			rx_tail_q    <= rx_tail_d;
			tx_head_q    <= tx_head_d;
			tx_tail_q    <= tx_tail_d;
			rx_used_q    <= rx_used_d;
			tx_pending_q <= tx_pending_d;
			tx_busy_q    <= tx_busy_d;
		end
	end

	// result fields captured with the beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_kind_q  <= res_kind_d;
			res_slot_q  <= res_slot_d;
			res_frame_q <= res_frame_d;
			res_src_q   <= res_src_d;
		end
	end

	// frame stores
	cfrb_ram #(
		.Width (FrameW),
		.Depth (RX_SLOTS)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_head_q),
		.wdata (rx_frame_in),
		.re    (rx_re),
		.raddr (rx_tail_q),
		.rdata (rx_rdata)
	);

	cfrb_ram #(
		.Width (FrameW),
		.Depth (TX_SLOTS)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_head_q),
		.wdata (tx_frame_in),
		.re    (tx_re),
		.raddr (tx_tail_q),
		.rdata (tx_rdata)
	);

	// assemble the result beat
	always_comb begin
		unique case (res_src_q)
			SRC_RX_MEM: frame_sel = rx_rdata;
			SRC_TX_MEM: frame_sel = tx_rdata;
			default:    frame_sel = res_frame_q;
		endcase
		rsp_d.kind          = res_kind_q;
		rsp_d.out_id        = frame_sel.id;
		rsp_d.out_length    = frame_sel.len;
		rsp_d.out_payload   = frame_sel.data;
		rsp_d.out_slot      = res_slot_q;
		rsp_d.packed_header = (res_kind_q == KIND_TX_LOAD) ? pack_id(frame_sel.id) : '0;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_store_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && rx_store) |=> rx_used_q[$past(rx_head_q)])
		else $error("stored slot not marked used");

	a_launch_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && tx_launch) |=> tx_busy_q)
		else $error("transmit launch did not set busy");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("result valid without emit");

	a_empty_read_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req.op == OP_HOST_READ && rx_head_q == rx_tail_q)
		|=> (rx_tail_q == $past(rx_tail_q)))
		else $error("empty read moved the receive tail");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/can_frame_ring_buffer_top.sv
`default_nettype none

// A beat is taken in idle; its result passes the result registers and the registered
// frame memory read, enters the output register at the emit step and is then valid
// on rsp. No new beat is taken until the last is emitted; an unused op code gives no
// result. A result waiting on rsp holds off the emit step, not the next accept.
// Reset (arst_n low, async): pointers, slot flags, transmitter busy and FSM clear;
// frame memories are not initialized.
module can_frame_ring_buffer_top import cfrb_pkg::*; #(
	parameter int RX_SLOTS = RxSlotsDefault,
	parameter int TX_SLOTS = TxSlotsDefault
) (
	input wire logic      clk,
	input wire logic      arst_n,
	cfrb_stream_if.sink   req,
	cfrb_stream_if.source rsp
);

	cmd_t cmd;
	sts_t sts;
	rsp_t rsp_data;
	logic rsp_valid;
	logic in_ready;

	cfrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	cfrb_datapath #(
		.RX_SLOTS (RX_SLOTS),
		.TX_SLOTS (TX_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready)
	);

	assign req.ready = in_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

endmodule

`default_nettype wire
